// ----- rtl/grcw_pkg.sv -----
// grcw_pkg: types, widths and constants of the grid ray cell walker
// no dependencies; imported by every module of the block

package grcw_pkg;

  // grid and field widths
  localparam int DEF_GRID_SIZE = 32;
  localparam int COORD_W       = 5;
  localparam int TILE_W        = 7;
  localparam int PIX_W         = 11;
  localparam int PIX_MAX       = 2047;
  localparam logic [TILE_W-1:0] TILE_RESET = 7'd32;

  // fixed point
  localparam int FRAC_W   = 16;
  localparam int POS_W    = 25;            // signed Q16 position
  localparam int CELL_W   = POS_W - FRAC_W; // signed rounded cell
  localparam int ALU_W    = 44;            // shared compare/subtract width
  localparam int D2_W     = 11;            // dx*dx + dy*dy
  localparam int LEN_W    = 22;            // Q16 ray length
  localparam int QUO_W    = 17;            // Q16 unit magnitude, up to 1.0
  localparam int UNIT_W   = QUO_W + 1;     // signed unit component

  // sequencing
  localparam int SQRT_ITERS = 22;          // first trial bit is 4^21
  localparam int ITER_W     = 5;
  localparam int MAX_STEPS  = 46;
  localparam int STEP_W     = 6;

  // stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_DIVX,
    ST_DIVY,
    ST_WALK
  } grcw_state_t;

endpackage

// ----- rtl/grcw_cmpsub.sv -----
// grcw_cmpsub: the shared compare-and-subtract unit
// used for every square root and division step; depends on grcw_pkg

module grcw_cmpsub
  import grcw_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  output logic [ALU_W-1:0] diff,
  output logic             ge
);

  logic [ALU_W:0] wide;

  // borrow out of the subtract gives the compare
  assign wide = {1'b0, a} - {1'b0, b};
  assign diff = wide[ALU_W-1:0];
  assign ge   = ~wide[ALU_W];

endmodule

// ----- rtl/grcw_cell.sv -----
// grcw_cell: one axis of a ray position to cell, clamp and pixel origin
// depends on grcw_pkg

module grcw_cell
  import grcw_pkg::*;
#(
  parameter int GRID_SIZE = DEF_GRID_SIZE
) (
  input  logic signed [POS_W-1:0]   pos,
  input  logic        [COORD_W-1:0] target,
  input  logic        [TILE_W-1:0]  tile,
  output logic        [COORD_W-1:0] cell_idx,
  output logic        [PIX_W-1:0]   pixel,
  output logic                      hit
);

  localparam logic [CELL_W-2:0] CELL_MAX = (CELL_W-1)'(GRID_SIZE - 1);

  logic signed [POS_W-1:0]  biased;
  logic signed [CELL_W-1:0] rounded;
  logic        [CELL_W-2:0] clamped;
  logic [CELL_W+TILE_W-2:0] product;

  // round half up: floor(pos + 1/2)
  assign biased  = pos + POS_W'(32'sd1 <<< (FRAC_W - 1));
  assign rounded = biased[POS_W-1:FRAC_W];
  assign hit     = (rounded == $signed({{(CELL_W-COORD_W){1'b0}}, target}));

  always_comb begin
    if (rounded[CELL_W-1]) begin
      clamped = '0;
    end else if (rounded[CELL_W-2:0] > CELL_MAX) begin
      clamped = CELL_MAX;
    end else begin
      clamped = rounded[CELL_W-2:0];
    end
  end

  assign product  = clamped * tile;
  assign cell_idx = clamped[COORD_W-1:0];
  assign pixel    = (product > (CELL_W+TILE_W-1)'(PIX_MAX)) ? PIX_W'(PIX_MAX)
                                                            : product[PIX_W-1:0];

endmodule

// ----- rtl/grid_ray_cell_walker.sv -----
// grid_ray_cell_walker: walks a ray of unit steps between two grid cells
// an item is accepted while idle, then the shared compare/subtract unit works out
// the ray length and then each of the two unit components in turn
// the walk then gives one cell per cycle (up to 46) while the output is taken;
// equal endpoints skip straight to the walk
// reset: synchronous active-low rst_n clears the sequencer, output valid and
// sets tile_size to 32; no memory, so no clearing pass

module grid_ray_cell_walker
  import grcw_pkg::*;
#(
  parameter int GRID_SIZE = DEF_GRID_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration: tile_size
  input  logic                  cfg_wr_en,
  input  logic [TILE_W-1:0]     cfg_wr_data,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // start_x, start_y, target_x, target_y, pad
  input  logic [0:0]            in_tuser,   // aiming
  // visited cell stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // cell_x, cell_y, pixel_x, pixel_y
  output logic                  out_tlast   // cell equals target
);

  // sequencer
  grcw_state_t state_r, state_nxt;

  // request
  logic [COORD_W-1:0] tx_r, ty_r;
  logic [COORD_W-1:0] mag_x_r, mag_y_r;
  logic               neg_x_r, neg_y_r;
  logic [TILE_W-1:0]  tile_r;

  // shared unit operands and iteration state
  logic [ALU_W-1:0]   rem_r, rem_nxt;
  logic [ALU_W-1:0]   root_r, root_nxt;
  logic [ALU_W-1:0]   div_r, div_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [ITER_W-1:0]  iter_r, iter_nxt;
  logic [ALU_W-1:0]   alu_b, alu_diff, trial_bit;
  logic               alu_ge;

  // walk
  logic signed [UNIT_W-1:0] ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic [STEP_W-1:0]        step_r, step_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r;

  // request unpacking
  logic                  in_xfer, go;
  logic [COORD_W-1:0]    in_sx, in_sy, in_tx, in_ty;
  logic [COORD_W:0]      dx, dy;
  logic [COORD_W-1:0]    in_mx, in_my;
  logic [D2_W-1:0]       d2;
  logic                  same_cell;

  // cell stage
  logic [COORD_W-1:0] cell_x, cell_y;
  logic [PIX_W-1:0]   pix_x, pix_y;
  logic               hit_x, hit_y, emit, walk_done;
  logic [QUO_W:0]     quo_ext;

  assign in_sx = in_tdata[COORD_W-1:0];
  assign in_sy = in_tdata[2*COORD_W-1:COORD_W];
  assign in_tx = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_ty = in_tdata[4*COORD_W-1:3*COORD_W];

  assign in_xfer   = in_tvalid && in_tready;
  // nothing to do when not aiming or the tile size is zero
  assign go        = in_xfer && in_tuser[0] && (tile_r != '0);
  assign same_cell = (in_sx == in_tx) && (in_sy == in_ty);

  assign dx    = {1'b0, in_tx} - {1'b0, in_sx};
  assign dy    = {1'b0, in_ty} - {1'b0, in_sy};
  assign in_mx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
  assign in_my = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
  assign d2    = D2_W'(in_mx) * D2_W'(in_mx) + D2_W'(in_my) * D2_W'(in_my);

  // trial bit of the square root is 4^iter, always clear in the partial root
  assign trial_bit = ALU_W'(1) << {iter_r, 1'b0};

  grcw_cmpsub u_cmpsub (
    .a    (rem_r),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  grcw_cell #(.GRID_SIZE(GRID_SIZE)) u_cell_x (
    .pos      (px_r),
    .target   (tx_r),
    .tile     (tile_r),
    .cell_idx (cell_x),
    .pixel    (pix_x),
    .hit      (hit_x)
  );

  grcw_cell #(.GRID_SIZE(GRID_SIZE)) u_cell_y (
    .pos      (py_r),
    .target   (ty_r),
    .tile     (tile_r),
    .cell_idx (cell_y),
    .pixel    (pix_y),
    .hit      (hit_y)
  );

  // a result goes out when the output register is free or being drained
  assign emit      = (state_r == ST_WALK) && (!out_valid_r || out_tready);
  // target reached or step guard hit
  assign walk_done = (hit_x && hit_y) || (step_r == STEP_W'(MAX_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (go) begin
          state_nxt = same_cell ? ST_WALK : ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (iter_r == '0) begin
          state_nxt = ST_DIVX;
        end
      end
      ST_DIVX: begin
        if (iter_r == '0) begin
          state_nxt = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (iter_r == '0) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (emit && walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    alu_b     = div_r;
    unique case (state_r)
      ST_IDLE: in_tready = 1'b1;
      ST_SQRT: alu_b     = root_r | trial_bit;
      ST_DIVX,
      ST_DIVY,
      ST_WALK: alu_b     = div_r;
      default: in_tready = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    div_nxt       = div_r;
    quo_nxt       = quo_r;
    iter_nxt      = iter_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    step_nxt      = step_r;
    quo_ext       = {1'b0, quo_r};
    out_valid_nxt = out_valid_r;

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        // length squared as Q32 into the remainder
        rem_nxt  = ALU_W'({d2, {(2*FRAC_W){1'b0}}});
        root_nxt = '0;
        iter_nxt = ITER_W'(SQRT_ITERS - 1);
        px_nxt   = POS_W'({in_sx, {FRAC_W{1'b0}}});
        py_nxt   = POS_W'({in_sy, {FRAC_W{1'b0}}});
        step_nxt = '0;
      end
      ST_SQRT: begin
        if (alu_ge) begin
          rem_nxt  = alu_diff;
          root_nxt = (root_r >> 1) | trial_bit;
        end else begin
          root_nxt = root_r >> 1;
        end
        iter_nxt = iter_r - 1'b1;
        if (iter_r == '0) begin
          // set up the x divide: |dx| << 32 over length << 16 first
          rem_nxt  = ALU_W'({mag_x_r, {(2*FRAC_W){1'b0}}});
          div_nxt  = ALU_W'({root_nxt[LEN_W-1:0], {(QUO_W-1){1'b0}}});
          quo_nxt  = '0;
          iter_nxt = ITER_W'(QUO_W - 1);
        end
      end
      ST_DIVX, ST_DIVY: begin
        if (alu_ge) begin
          rem_nxt = alu_diff;
        end
        quo_nxt  = {quo_r[QUO_W-2:0], alu_ge};
        div_nxt  = div_r >> 1;
        iter_nxt = iter_r - 1'b1;
        quo_ext  = {1'b0, quo_nxt};
        if (iter_r == '0) begin
          if (state_r == ST_DIVX) begin
            ux_nxt   = neg_x_r ? -$signed(quo_ext) : $signed(quo_ext);
            rem_nxt  = ALU_W'({mag_y_r, {(2*FRAC_W){1'b0}}});
            div_nxt  = ALU_W'({root_r[LEN_W-1:0], {(QUO_W-1){1'b0}}});
            quo_nxt  = '0;
            iter_nxt = ITER_W'(QUO_W - 1);
          end else begin
            uy_nxt = neg_y_r ? -$signed(quo_ext) : $signed(quo_ext);
          end
        end
      end
      ST_WALK: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          step_nxt      = step_r + 1'b1;
          px_nxt        = px_r + POS_W'(ux_r);
          py_nxt        = py_r + POS_W'(uy_r);
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      tile_r      <= TILE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        tile_r <= cfg_wr_data;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      tx_r    <= in_tx;
      ty_r    <= in_ty;
      mag_x_r <= in_mx;
      mag_y_r <= in_my;
      neg_x_r <= dx[COORD_W];
      neg_y_r <= dy[COORD_W];
    end
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    div_r  <= div_nxt;
    quo_r  <= quo_nxt;
    iter_r <= iter_nxt;
    ux_r   <= ux_nxt;
    uy_r   <= uy_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    step_r <= step_nxt;
    if (emit) begin
      out_data_r <= {pix_y, pix_x, cell_y, cell_x};
      out_last_r <= hit_x && hit_y;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/grcw_checker.sv -----
// grcw_checker: port-level checks on the grid ray cell walker
// depends on grcw_pkg; bound to grid_ray_cell_walker at the end of this file

module grcw_checker
  import grcw_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [0:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a request that is not aiming leaves the block idle
  a_no_aim_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> in_tready)
    else $error("block went busy on a request that is not aiming");

  // the block only goes busy on an accepted request
  a_busy_on_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready && $past(in_tready) && $past(rst_n) |-> $past(in_tvalid))
    else $error("block went busy without a request transfer");

  // no new result appears while the block stays idle
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready && $past(in_tready) && $past(rst_n) && $past(out_tvalid && out_tready)
      |-> !out_tvalid)
    else $error("result appeared while idle");

endmodule

bind grid_ray_cell_walker grcw_checker u_grcw_checker (.*);
